// ----- src/rational_add_mul_compare_defines.svh -----
// Assertion macros used by the checker file.
`ifndef RATIONAL_ADD_MUL_COMPARE_DEFINES_SVH
`define RATIONAL_ADD_MUL_COMPARE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RAMC_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rational unit check failed");

// Implication checked on every clock edge, reset included.
`define RAMC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rational unit check failed");

`endif

// ----- src/ramc_pkg.sv -----
package ramc_pkg;

    localparam int unsigned DEN_W  = 16;
    localparam int unsigned RNUM_W = 33;
    localparam int unsigned RDEN_W = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_CMP = 2'd2,
        OP_RSV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ORD_LESS    = 2'd0,
        ORD_EQUAL   = 2'd1,
        ORD_GREATER = 2'd2,
        ORD_RSV     = 2'd3
    } order_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } ramc_state_t;

    // Start / busy pair between the sequencer and a multiplier, divider or gcd unit.
    typedef struct packed {
        logic start;
        logic busy;
    } unit_ctl_t;

endpackage

// ----- src/ramc_mul.sv -----
// Shift-add multiplier: one multiplier bit a cycle, unsigned magnitudes.
module ramc_mul #(
    parameter int unsigned AW = 16,
    parameter int unsigned BW = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [AW-1:0]     a,
    input  logic [BW-1:0]     b,
    output logic              busy,
    output logic [AW+BW-1:0]  prod
);
    localparam int unsigned CW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] mcand_reg, mcand_next;
    logic [BW-1:0]    mplier_reg, mplier_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        if (start) begin
            acc_next    = '0;
            mcand_next  = {{BW{1'b0}}, a};
            mplier_next = b;
            cnt_next    = CW'(BW);
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;
endmodule

// ----- src/ramc_div.sv -----
// Restoring divider: one quotient bit a cycle.
module ramc_div #(
    parameter int unsigned W = 34
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    output logic          busy,
    output logic [W-1:0]  quot
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;

    always_comb begin
        q_next   = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[W-1:0], q_reg[W-1]};
        if (start) begin
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(W);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule

// ----- src/ramc_gcd.sv -----
// Binary gcd: one halving or subtraction step a cycle. Both inputs non-zero
// is not required of x; y is always non-zero.
module ramc_gcd #(
    parameter int unsigned W = 34
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [W-1:0]  x,
    input  logic [W-1:0]  y,
    output logic          busy,
    output logic [W-1:0]  g
);
    localparam int unsigned SW = $clog2(W + 1);

    logic [W-1:0]  u_reg, u_next;
    logic [W-1:0]  v_reg, v_next;
    logic [SW-1:0] sh_reg, sh_next;
    logic          run_reg, run_next;

    always_comb begin
        u_next   = u_reg;
        v_next   = v_reg;
        sh_next  = sh_reg;
        run_next = run_reg;
        if (start) begin
            u_next   = x;
            v_next   = y;
            sh_next  = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            priority if (u_reg == '0) begin
                run_next = 1'b0;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_next  = u_reg >> 1;
                v_next  = v_reg >> 1;
                sh_next = sh_reg + SW'(1);
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (u_reg >= v_reg) begin
                u_next = (u_reg - v_reg) >> 1;
            end else begin
                v_next = (v_reg - u_reg) >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
        end
        u_reg  <= u_next;
        v_reg  <= v_next;
        sh_reg <= sh_next;
    end

    assign busy = run_reg;
    assign g    = v_reg << sh_reg;
endmodule

// ----- src/rational_add_mul_compare.sv -----
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_op, s_a_num, s_a_den, s_b_num, s_b_den
// m_       | out       | m_valid / m_ready  | m_res_num, m_res_den, m_order, m_den_error
//
// One beat in the sequencer at a time. Add/multiply: serial NUM_WIDTH+16 products, a sum,
// a binary gcd and two serial divides. Compare runs the products only; a zero
// denominator skips the products and goes from ST_MUL straight to ST_DONE.
// Reset (aresetn low, synchronous) empties the sequencer and the result slot.
// s_ready is high whenever the sequencer is idle; a held result only parks the
// next beat at its last step until the result slot frees.
module rational_add_mul_compare #(
    parameter int unsigned NUM_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_op,
    input  logic signed [NUM_WIDTH-1:0] s_a_num,
    input  logic [15:0]                s_a_den,
    input  logic signed [NUM_WIDTH-1:0] s_b_num,
    input  logic [15:0]                s_b_den,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [32:0]         m_res_num,
    output logic [31:0]                m_res_den,
    output logic [1:0]                 m_order,
    output logic                       m_den_error
);
    import ramc_pkg::*;

    // Product magnitudes are NUM_WIDTH+16 bits; the sum needs one more bit,
    // and den*den is 32 bits, so W is the larger of the two.
    localparam int unsigned PW = NUM_WIDTH + DEN_W;
    localparam int unsigned W  = (PW + 1 > 2 * DEN_W) ? PW + 1 : 2 * DEN_W;

    ramc_state_t state_reg, state_next;

    logic [1:0]             op_reg;
    logic [NUM_WIDTH-1:0]   an_reg, bn_reg;
    logic [DEN_W-1:0]       ad_reg, bd_reg;
    logic                   an_neg, bn_neg;
    logic [NUM_WIDTH-1:0]   an_mag, bn_mag;

    logic signed [W:0]      l_reg, r_reg;
    logic [W-1:0]           nmag_reg, dd_reg, g_reg;
    logic                   nneg_reg;
    logic [W-1:0]           qn_reg;

    logic                   out_valid_reg;
    logic signed [32:0]     out_num_reg;
    logic [31:0]            out_den_reg;
    order_t                 out_ord_reg;
    logic                   out_err_reg;

    unit_ctl_t m1_ctl, m2_ctl, m3_ctl, g_ctl, d_ctl;
    logic [PW-1:0]          p1, p2;
    logic [2*DEN_W-1:0]     p3;
    logic [W-1:0]           g_out, d_quot;
    logic [W-1:0]           d_dividend;
    logic                   accept, load_done;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign an_neg = an_reg[NUM_WIDTH-1];
    assign bn_neg = bn_reg[NUM_WIDTH-1];
    assign an_mag = an_neg ? (~an_reg + NUM_WIDTH'(1)) : an_reg;
    assign bn_mag = bn_neg ? (~bn_reg + NUM_WIDTH'(1)) : bn_reg;

    // Cross products for add and compare; multiply takes its product from u_muln.
    logic [NUM_WIDTH-1:0] m1_a, m2_a;
    logic [DEN_W-1:0]     m1_b, m2_b;
    always_comb begin
        m1_a = an_mag;
        m1_b = bd_reg;
        m2_a = bn_mag;
        m2_b = ad_reg;
    end

    // Multiply needs a NUM x NUM product; use a separate unit sized for it.
    logic [2*NUM_WIDTH-1:0] pnn;
    unit_ctl_t mn_ctl;

    ramc_mul #(.AW(NUM_WIDTH), .BW(DEN_W)) u_mul1 (
        .aclk, .aresetn, .start(m1_ctl.start), .a(m1_a), .b(m1_b),
        .busy(m1_ctl.busy), .prod(p1)
    );
    ramc_mul #(.AW(NUM_WIDTH), .BW(DEN_W)) u_mul2 (
        .aclk, .aresetn, .start(m2_ctl.start), .a(m2_a), .b(m2_b),
        .busy(m2_ctl.busy), .prod(p2)
    );
    ramc_mul #(.AW(DEN_W), .BW(DEN_W)) u_mul3 (
        .aclk, .aresetn, .start(m3_ctl.start), .a(ad_reg), .b(bd_reg),
        .busy(m3_ctl.busy), .prod(p3)
    );
    ramc_mul #(.AW(NUM_WIDTH), .BW(NUM_WIDTH)) u_muln (
        .aclk, .aresetn, .start(mn_ctl.start), .a(an_mag), .b(bn_mag),
        .busy(mn_ctl.busy), .prod(pnn)
    );

    // Unsigned magnitude products resized to W+1 bits.
    localparam int unsigned NW = 2 * NUM_WIDTH;
    logic [W:0] pnn_w, p1_w, p2_w;
    assign pnn_w = (NW >= W + 1) ? (W+1)'(pnn) : (W+1)'({{(W+1){1'b0}}, pnn});
    assign p1_w  = (W+1)'({{(W+1){1'b0}}, p1});
    assign p2_w  = (W+1)'({{(W+1){1'b0}}, p2});

    // The gcd unit holds its result once it stops, so both divides read it directly.
    ramc_gcd #(.W(W)) u_gcd (
        .aclk, .aresetn, .start(g_ctl.start), .x(nmag_reg), .y(dd_reg),
        .busy(g_ctl.busy), .g(g_out)
    );
    ramc_div #(.W(W)) u_div (
        .aclk, .aresetn, .start(d_ctl.start), .dividend(d_dividend),
        .divisor(g_out), .busy(d_ctl.busy), .quot(d_quot)
    );

    logic mul_busy;
    assign mul_busy = m1_ctl.busy || m2_ctl.busy || m3_ctl.busy || mn_ctl.busy;

    // Sequencer: next state and unit starts.
    always_comb begin
        state_next   = state_reg;
        m1_ctl.start = 1'b0;
        m2_ctl.start = 1'b0;
        m3_ctl.start = 1'b0;
        mn_ctl.start = 1'b0;
        g_ctl.start  = 1'b0;
        d_ctl.start  = 1'b0;
        d_dividend   = nmag_reg;
        load_done    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (ad_reg == '0 || bd_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    m1_ctl.start = 1'b1;
                    m2_ctl.start = 1'b1;
                    m3_ctl.start = 1'b1;
                    mn_ctl.start = 1'b1;
                    state_next   = ST_SUM;
                end
            end
            ST_SUM: begin
                if (!mul_busy) begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (op_reg == OP_CMP || op_reg == OP_RSV) begin
                    state_next = ST_DONE;
                end else if (!g_ctl.busy && g_reg == '0) begin
                    g_ctl.start = 1'b1;
                    state_next  = ST_DIVN;
                end
            end
            ST_DIVN: begin
                if (!g_ctl.busy && !d_ctl.busy) begin
                    d_ctl.start = 1'b1;
                    d_dividend  = nmag_reg;
                    state_next  = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (!d_ctl.busy) begin
                    d_ctl.start = 1'b1;
                    d_dividend  = dd_reg;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold here until the divider is idle and the result slot is free or being drained
                if (!d_ctl.busy && (!out_valid_reg || m_ready)) begin
                    load_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    logic signed [W:0] l_s, r_s, nsum;
    always_comb begin
        l_s  = (an_neg ? -$signed(p1_w) : $signed(p1_w));
        r_s  = (bn_neg ? -$signed(p2_w) : $signed(p2_w));
        if (op_reg == OP_MUL) begin
            nsum = (an_neg ^ bn_neg) ? -$signed(pnn_w) : $signed(pnn_w);
        end else begin
            nsum = l_s + r_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg <= s_op;
            an_reg <= s_a_num;
            bn_reg <= s_b_num;
            ad_reg <= s_a_den;
            bd_reg <= s_b_den;
        end
        if (state_reg == ST_SUM && !mul_busy) begin
            l_reg    <= l_s;
            r_reg    <= r_s;
            nneg_reg <= nsum[W];
            nmag_reg <= nsum[W] ? W'(-nsum) : W'(nsum);
            dd_reg   <= W'(p3);
            g_reg    <= '0;
        end
        if (state_reg == ST_DIVN && !g_ctl.busy && !d_ctl.busy) begin
            g_reg <= g_out;
        end
        if (state_reg == ST_DIVD && !d_ctl.busy) begin
            qn_reg <= d_quot;
        end
    end

    // Result slot.
    logic signed [W:0] qn_s;
    assign qn_s = nneg_reg ? -$signed({1'b0, qn_reg}) : $signed({1'b0, qn_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (load_done) begin
            out_num_reg <= '0;
            out_den_reg <= 32'd1;
            out_ord_reg <= ORD_LESS;
            out_err_reg <= 1'b0;
            if (ad_reg == '0 || bd_reg == '0) begin
                out_ord_reg <= ORD_EQUAL;
                out_err_reg <= 1'b1;
            end else if (op_reg == OP_CMP || op_reg == OP_RSV) begin
                out_ord_reg <= (l_reg < r_reg) ? ORD_LESS :
                               ((l_reg > r_reg) ? ORD_GREATER : ORD_EQUAL);
            end else begin
                out_num_reg <= 33'(qn_s);
                out_den_reg <= 32'(d_quot);
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_res_num   = out_num_reg;
    assign m_res_den   = out_den_reg;
    assign m_order     = out_ord_reg;
    assign m_den_error = out_err_reg;
endmodule

// ----- src/ramc_checker.sv -----
`include "rational_add_mul_compare_defines.svh"

module ramc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_res_den,
    input logic [1:0]  m_order,
    input logic        m_den_error
);
    import ramc_pkg::*;

    `RAMC_ASSERT(a_hold_den, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_res_den))
    `RAMC_ASSERT(a_den_nonzero, aclk, aresetn, m_valid |-> m_res_den != 32'd0)
    `RAMC_ASSERT(a_err_equal, aclk, aresetn, (m_valid && m_den_error) |-> m_order == ORD_EQUAL)
    `RAMC_ASSERT(a_hold_out, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)
    `RAMC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)
endmodule

bind rational_add_mul_compare ramc_checker u_ramc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_res_den, .m_order, .m_den_error
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import ramc_pkg::*;

    localparam int NW          = 16;
    localparam int N_RANDOM    = 1330;
    localparam int CALM_TAIL   = 150;   // beats at the end sent with no idling
    localparam int STALL_LIMIT = 6000;  // cycles with no beat on either side
    localparam int LONG_HOLD   = 700;   // receiver hold-off that backs up the input

    // One operand beat and one result beat, at the widths of the ports.
    typedef struct packed {
        op_t                  op;
        logic signed [NW-1:0] a_num;
        logic [15:0]          a_den;
        logic signed [NW-1:0] b_num;
        logic [15:0]          b_den;
    } operands_t;

    typedef struct packed {
        logic signed [32:0] res_num;
        logic [31:0]        res_den;
        order_t             order;
        logic               den_error;
    } fraction_res_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    logic [1:0] s_op;
    logic signed [NW-1:0] s_a_num, s_b_num;
    logic [15:0] s_a_den, s_b_den;
    logic signed [32:0] m_res_num;
    logic [31:0] m_res_den;
    logic [1:0] m_order;
    logic m_den_error;

    operands_t     pending_ops[$];
    fraction_res_t awaited_fracs[$];
    int mismatches = 0;
    int drv_idle = 0;
    int rx_stall = 0;
    int rx_hold = 0;
    bit hold_done = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    rational_add_mul_compare #(.NUM_WIDTH(NW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_op), .s_a_num(s_a_num), .s_a_den(s_a_den),
        .s_b_num(s_b_num), .s_b_den(s_b_den),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_res_num(m_res_num), .m_res_den(m_res_den),
        .m_order(m_order), .m_den_error(m_den_error)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Euclid on magnitudes; y is a non-zero denominator on first call.
    function automatic longint unsigned common_divisor(longint unsigned x,
                                                       longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Reduce num/den by their gcd and wrap to the port widths.
    function automatic fraction_res_t reduced(longint num, longint unsigned den);
        fraction_res_t r;
        longint unsigned mag;
        longint unsigned g;
        longint q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        g = common_divisor(mag, den);
        q = num / longint'(g);
        r.res_num = q[32:0];
        r.res_den = 32'(den / g);
        r.order = ORD_LESS;
        r.den_error = 1'b0;
        return r;
    endfunction

    // Work out the result beat that one operand beat must produce.
    function automatic fraction_res_t rational_result(operands_t x);
        fraction_res_t r;
        longint an, bn, ad, bd, lhs, rhs;
        an = x.a_num;
        bn = x.b_num;
        ad = longint'({1'b0, x.a_den});
        bd = longint'({1'b0, x.b_den});
        r.res_num = '0;
        r.res_den = 32'd1;
        r.den_error = 1'b0;
        r.order = ORD_EQUAL;
        if (ad == 0 || bd == 0) begin
            r.den_error = 1'b1;
        end else if (x.op == OP_ADD) begin
            r = reduced(an * bd + bn * ad, ad * bd);
        end else if (x.op == OP_MUL) begin
            r = reduced(an * bn, ad * bd);
        end else begin
            // compare, and the spare code that acts as one
            lhs = an * bd;
            rhs = bn * ad;
            r.order = (lhs < rhs) ? ORD_LESS : ((lhs > rhs) ? ORD_GREATER : ORD_EQUAL);
        end
        return r;
    endfunction

    function automatic operands_t make_ops(op_t op, int an, int ad, int bn, int bd);
        operands_t x;
        x.op = op;
        x.a_num = an[NW-1:0];
        x.a_den = ad[15:0];
        x.b_num = bn[NW-1:0];
        x.b_den = bd[15:0];
        return x;
    endfunction

    // Pick a numerator: mostly full range, sometimes tiny for real reduction.
    function automatic int rand_num();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return $signed(16'($urandom));
        else if (k < 8)
            return int'($urandom_range(0, 40)) - 20;
        else
            return (k == 8) ? -32768 : 32767;
    endfunction

    function automatic int rand_den();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 0;
        else if (k < 10)
            return $urandom_range(1, 65535);
        else if (k < 18)
            return $urandom_range(1, 48);
        else
            return 65535;
    endfunction

    // Fill the queue: directed corners first, then random beats.
    initial begin
        op_t op;
        pending_ops.push_back(make_ops(OP_ADD, 32767, 1, 32767, 1));
        pending_ops.push_back(make_ops(OP_ADD, -32768, 65535, -32768, 65535));
        pending_ops.push_back(make_ops(OP_ADD, 1, 2, -1, 2));
        pending_ops.push_back(make_ops(OP_ADD, 0, 7, 0, 9));
        pending_ops.push_back(make_ops(OP_ADD, -32768, 1, -32768, 1));
        pending_ops.push_back(make_ops(OP_ADD, 1, 65535, 1, 65534));
        pending_ops.push_back(make_ops(OP_MUL, -32768, 1, -32768, 1));
        pending_ops.push_back(make_ops(OP_MUL, 32767, 65535, -32768, 65535));
        pending_ops.push_back(make_ops(OP_MUL, 6, 4, -2, 9));
        pending_ops.push_back(make_ops(OP_MUL, 0, 65535, 5, 3));
        pending_ops.push_back(make_ops(OP_CMP, 1, 2, 2, 4));
        pending_ops.push_back(make_ops(OP_CMP, -1, 3, 1, 3));
        pending_ops.push_back(make_ops(OP_CMP, 32767, 1, -32768, 1));
        pending_ops.push_back(make_ops(OP_CMP, -32768, 65535, -32768, 1));
        pending_ops.push_back(make_ops(OP_RSV, -5, 2, 3, 7));
        pending_ops.push_back(make_ops(OP_RSV, 4, 8, 1, 2));
        pending_ops.push_back(make_ops(OP_ADD, 3, 0, 4, 5));
        pending_ops.push_back(make_ops(OP_MUL, 3, 5, 4, 0));
        pending_ops.push_back(make_ops(OP_CMP, 3, 0, 4, 0));
        pending_ops.push_back(make_ops(OP_RSV, -32768, 0, 32767, 65535));
        for (int i = 0; i < N_RANDOM; i++) begin
            op = op_t'($urandom_range(0, 3));
            pending_ops.push_back(make_ops(op, rand_num(), rand_den(), rand_num(), rand_den()));
        end
    end

    // Reset, then wait for the traffic to drain and give the verdict.
    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        wait (pending_ops.size() == 0 && !s_valid && awaited_fracs.size() == 0);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && awaited_fracs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Driver: hold the beat until taken, then advance or idle for a burst.
    always @(posedge aclk) begin
        operands_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_op    <= OP_ADD;
            s_a_num <= '0;
            s_a_den <= '0;
            s_b_num <= '0;
            s_b_den <= '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready)
                awaited_fracs.push_back(rational_result(
                    make_ops(op_t'(s_op), s_a_num, s_a_den, s_b_num, s_b_den)));
            if (drv_idle > 0) begin
                drv_idle <= drv_idle - 1;
                s_valid  <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                nxt = pending_ops.pop_front();
                s_valid <= 1'b1;
                s_op    <= nxt.op;
                s_a_num <= nxt.a_num;
                s_a_den <= nxt.a_den;
                s_b_num <= nxt.b_num;
                s_b_den <= nxt.b_den;
                // drop into an idle burst now and then, never in the calm tail
                if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
                    drv_idle <= $urandom_range(1, 5);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge aclk) begin
        fraction_res_t want;
        fraction_res_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                got = '{m_res_num, m_res_den, order_t'(m_order), m_den_error};
                if (awaited_fracs.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result beat num=%0d den=%0d ord=%0d err=%0b",
                                 m_res_num, m_res_den, m_order, m_den_error);
                end else begin
                    want = awaited_fracs.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"result mismatch: want num=%0d den=%0d ord=%0d err=%0b",
                                      " got num=%0d den=%0d ord=%0d err=%0b"},
                                     want.res_num, want.res_den, want.order, want.den_error,
                                     got.res_num, got.res_den, got.order, got.den_error);
                    end
                end
            end
            // One long hold-off early on so the sender backs up behind a full block.
            if (!hold_done && results_seen == 200) begin
                hold_done <= 1'b1;
                rx_hold   <= LONG_HOLD;
                m_ready   <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_ready <= (rx_hold == 1);
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_ready  <= (rx_stall == 1);
            end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
                rx_stall <= $urandom_range(1, 5);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+src
src/ramc_pkg.sv
src/ramc_mul.sv
src/ramc_div.sv
src/ramc_gcd.sv
src/rational_add_mul_compare.sv
src/ramc_checker.sv
test/tb_top.sv
